/* rtl/edst_pkg.sv */
// Shared constants and types for the EU DST local time breakdown block.
// Holds reciprocal constants for the constant dividers; no dependencies.
package edst_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_DST    = 1'b1;

  // Civil calendar constants
  localparam logic [19:0] Z_OFS   = 20'd719468;
  localparam logic [19:0] ERA5_Z  = 20'd730485;
  localparam logic [19:0] ERA4_Z  = 20'd584388;
  localparam logic [17:0] DOE_MAX = 18'd146096;

  // floor(x/c) = (x*M) >> S, exact for the operand widths used
  localparam int unsigned S675   = 35;
  localparam logic [25:0] M675   = 26'(((64'd1 << S675) + 64'd674) / 64'd675);
  localparam int unsigned S1460  = 29;
  localparam logic [18:0] M1460  = 19'(((64'd1 << S1460) + 64'd1459) / 64'd1460);
  localparam int unsigned S36524 = 34;
  localparam logic [18:0] M36524 = 19'(((64'd1 << S36524) + 64'd36523) / 64'd36524);
  localparam int unsigned S365   = 27;
  localparam logic [18:0] M365   = 19'(((64'd1 << S365) + 64'd364) / 64'd365);
  localparam int unsigned S100   = 16;
  localparam logic [9:0]  M100   = 10'(((64'd1 << S100) + 64'd99) / 64'd100);
  localparam int unsigned S153   = 19;
  localparam logic [11:0] M153   = 12'(((64'd1 << S153) + 64'd152) / 64'd153);
  localparam int unsigned S5     = 14;
  localparam logic [11:0] M5     = 12'(((64'd1 << S5) + 64'd4) / 64'd5);
  localparam int unsigned S7     = 19;
  localparam logic [16:0] M7     = 17'(((64'd1 << S7) + 64'd6) / 64'd7);
  localparam int unsigned S3600  = 29;
  localparam logic [17:0] M3600  = 18'(((64'd1 << S3600) + 64'd3599) / 64'd3600);
  localparam int unsigned S60    = 18;
  localparam logic [12:0] M60    = 13'(((64'd1 << S60) + 64'd59) / 64'd60);

  typedef struct packed {
    logic [31:0]        utc;
    logic [15:0]        ud;
    logic [16:0]        usecs;
    logic               sync;
    logic signed [10:0] base;
    logic               auto_dst;
  } utc_ctx_t;

  typedef struct packed {
    logic [31:0]        local_sec;
    logic signed [10:0] off;
    logic               dst;
    logic               sync;
  } loc_ctx_t;

  typedef struct packed {
    loc_ctx_t   ctx;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
  } hms_ctx_t;

endpackage

/* rtl/edst_in_if.sv */
// Input channel of the DST local time block: valid/ready plus one UTC stamp and a synced flag.
// No dependencies.
interface edst_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] utc_seconds;
  logic        clock_synced;
  modport source (output valid, utc_seconds, clock_synced, input ready);
  modport sink   (input valid, utc_seconds, clock_synced, output ready);
endinterface

/* rtl/edst_out_if.sv */
// Output channel of the DST local time block: valid/ready plus broken-down time.
// No dependencies.
interface edst_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        local_seconds;
  logic [11:0]        local_year;
  logic [3:0]         local_month;
  logic [4:0]         local_day;
  logic [4:0]         local_hour;
  logic [5:0]         local_minute;
  logic [5:0]         local_second;
  logic [2:0]         week_day;
  logic               summer_time;
  logic signed [10:0] offset_minutes;
  modport source (output valid, local_seconds, local_year, local_month, local_day,
                  local_hour, local_minute, local_second, week_day, summer_time,
                  offset_minutes, input ready);
  modport sink   (input valid, local_seconds, local_year, local_month, local_day,
                  local_hour, local_minute, local_second, week_day, summer_time,
                  offset_minutes, output ready);
endinterface

/* rtl/edst_civil.sv */
// Nine-stage pipelined conversion of an epoch day count to year, month, day.
// Depends on edst_pkg; carries an opaque sideband alongside each item.
module edst_civil #(
  parameter int unsigned SbW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [15:0]      days_i,
  input  logic [SbW-1:0]   sb_i,
  output logic             valid_o,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_o,
  output logic [SbW-1:0]   sb_o
);
  import edst_pkg::*;

  logic [8:0]     vld_q;
  logic [7:0]     era_q;
  logic [SbW-1:0] sb_q [9];

  logic [19:0] z;
  logic        era5;
  logic [17:0] doe;
  logic [17:0] c1_doe_q;
  logic [36:0] p1460, p36524;
  logic [6:0]  c2_q1_q;
  logic [2:0]  c2_q2_q;
  logic [17:0] c2_doe_q;
  logic [17:0] c3_n_q, c3_doe_q;
  logic [36:0] p365;
  logic [8:0]  c4_yoe_q;
  logic [17:0] c4_doe_q;
  logic [18:0] p100;
  logic [1:0]  c5_c100_q;
  logic [17:0] c5_y365_q, c5_doe_q;
  logic [8:0]  c5_yoe_q;
  logic [17:0] doy_w;
  logic [8:0]  c6_doy_q, c6_yoe_q;
  logic [10:0] t153;
  logic [22:0] p153;
  logic [3:0]  c7_mp_q;
  logic [8:0]  c7_doy_q, c7_yoe_q;
  logic [10:0] u5;
  logic [22:0] p5;
  logic [8:0]  c8_q_q, c8_doy_q, c8_yoe_q;
  logic [3:0]  c8_mp_q;
  logic [3:0]  month_d;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[7:0], valid_i};
    end
  end

  assign z    = 20'(days_i) + Z_OFS;
  assign era5 = (z >= ERA5_Z);
  assign doe  = 18'(z - (era5 ? ERA5_Z : ERA4_Z));

  assign p1460  = 37'(c1_doe_q) * 37'(M1460);
  assign p36524 = 37'(c1_doe_q) * 37'(M36524);
  assign p365   = 37'(c3_n_q) * 37'(M365);
  assign p100   = 19'(c4_yoe_q) * 19'(M100);
  assign doy_w  = c5_doe_q - (c5_y365_q + 18'(c5_yoe_q[8:2]) - 18'(c5_c100_q));
  assign t153   = 11'({c6_doy_q, 2'b00}) + 11'(c6_doy_q) + 11'd2;
  assign p153   = 23'(t153) * 23'(M153);
  assign u5     = 11'(c7_mp_q) * 11'd153 + 11'd2;
  assign p5     = 23'(u5) * 23'(M5);
  assign month_d = (c8_mp_q < 4'd10) ? c8_mp_q + 4'd3 : c8_mp_q - 4'd9;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      for (int i = 1; i < 9; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
      era_q     <= {era_q[6:0], era5};
      c1_doe_q  <= doe;
      c2_q1_q   <= p1460[35:29];
      c2_q2_q   <= p36524[36:34];
      c2_doe_q  <= c1_doe_q;
      c3_n_q    <= c2_doe_q - 18'(c2_q1_q) + 18'(c2_q2_q) - 18'(c2_doe_q == DOE_MAX);
      c3_doe_q  <= c2_doe_q;
      c4_yoe_q  <= p365[35:27];
      c4_doe_q  <= c3_doe_q;
      c5_c100_q <= p100[17:16];
      c5_y365_q <= 18'(c4_yoe_q) * 18'd365;
      c5_yoe_q  <= c4_yoe_q;
      c5_doe_q  <= c4_doe_q;
      c6_doy_q  <= doy_w[8:0];
      c6_yoe_q  <= c5_yoe_q;
      c7_mp_q   <= p153[22:19];
      c7_doy_q  <= c6_doy_q;
      c7_yoe_q  <= c6_yoe_q;
      c8_q_q    <= p5[22:14];
      c8_mp_q   <= c7_mp_q;
      c8_doy_q  <= c7_doy_q;
      c8_yoe_q  <= c7_yoe_q;
      day_q     <= 5'(c8_doy_q - c8_q_q + 9'd1);
      month_q   <= month_d;
      year_q    <= 12'(c8_yoe_q) + (era_q[7] ? 12'd2000 : 12'd1600)
                   + 12'(month_d <= 4'd2);
    end
  end

  assign valid_o = vld_q[8];
  assign sb_o    = sb_q[8];
  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

/* rtl/eu_dst_local_time_breakdown_top.sv */
// Top level: UTC stamp to local civil time with the EU summer time rule.
// Depends on edst_pkg, edst_in_if, edst_out_if and edst_civil.
//
// Usage:
//  - in_ch carries a UTC second count and a synced flag; out_ch returns one
//    result per transfer: local epoch, date, time, weekday, DST flag, offset.
//  - cfg_we_i/cfg_idx_i/cfg_wdata_i write the base offset (index 0, signed
//    minutes) and the auto DST enable (index 1). Write only while idle.
//  - Throughput: one item per cycle. Every stage holds a valid bit and the
//    whole pipeline advances together, so a full pipeline takes a new item
//    each cycle that the output is free or being taken.
//  - Pipeline: 33 register stages from input transfer to output register:
//    3 for the UTC day split, 9 for the UTC calendar year, 5 for the DST
//    bounds and offset, 6 for the local day split and time of day, 9 for
//    the local calendar date and 1 output register.
//  - When the receiver stalls, every stage holds and in_ch.ready drops in
//    the same cycle; nothing is dropped or repeated.
//  - Reset clears all valid bits and sets the base offset and DST enable
//    to zero.
//  - With the synced flag clear, all fields are zero except the offset,
//    which shows the base offset.
module eu_dst_local_time_breakdown_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  edst_in_if.sink                               in_ch,
  edst_out_if.source                            out_ch,
  input  logic                                  cfg_we_i,
  input  logic [edst_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [edst_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import edst_pkg::*;

  logic               adv;
  logic signed [10:0] base_q;
  logic               auto_q;

  // UTC split
  logic        s0_v_q, s1_v_q, s2_v_q;
  logic [31:0] s0_utc_q, s1_utc_q;
  logic        s0_sync_q, s1_sync_q;
  logic signed [10:0] s0_base_q, s1_base_q;
  logic        s0_auto_q, s1_auto_q;
  logic [50:0] p_ud;
  logic [15:0] s1_ud_q;
  utc_ctx_t    s2_q;

  // UTC calendar
  logic                       c1_v;
  logic [11:0]                c1_year;
  logic [3:0]                 c1_month;
  logic [4:0]                 c1_day;
  logic [$bits(utc_ctx_t)-1:0] c1_sb;
  utc_ctx_t                   c1_ctx;

  // DST bounds
  logic [16:0] d_mar1;
  logic        d1_v_q, d2_v_q, d3_v_q, d4_v_q, d5_v_q;
  utc_ctx_t    d1_q, d2_q, d3_q;
  logic [16:0] d1_m_q, d1_o_q, d2_m_q, d2_o_q, d3_m_q, d3_o_q;
  logic [33:0] p_wm, p_wo;
  logic [12:0] d2_qm_q, d2_qo_q;
  logic [2:0]  wdm, wdo;
  logic        aft_start, bef_end, dst_d;
  logic signed [11:0] off_d, d4_off_q;
  logic        d4_dst_q, d4_sync_q;
  logic [31:0] d4_utc_q;
  logic signed [17:0] off_sec;
  loc_ctx_t    d5_q;

  // Local split
  logic        l1_v_q, l2_v_q, l3_v_q, l4_v_q, l5_v_q, l6_v_q;
  loc_ctx_t    l1_q, l2_q, l3_q, l4_q, l5_q;
  logic [50:0] p_ld;
  logic [15:0] l1_ld_q, l2_ld_q, l3_ld_q, l4_ld_q, l5_ld_q, l6_ld_q;
  logic [16:0] l2_secs_q, l3_secs_q;
  logic [34:0] p_hr;
  logic [33:0] p_wd;
  logic [4:0]  l3_hour_q, l4_hour_q, l5_hour_q;
  logic [12:0] l3_wq_q;
  logic [11:0] l4_rem_q, l5_rem_q;
  logic [2:0]  l4_wd_q, l5_wd_q;
  logic [24:0] p_mn;
  logic [5:0]  l5_min_q;
  hms_ctx_t    l6_q;

  // Local calendar and output
  logic                        c2_v;
  logic [11:0]                 c2_year;
  logic [3:0]                  c2_month;
  logic [4:0]                  c2_day;
  logic [$bits(hms_ctx_t)-1:0] c2_sb;
  hms_ctx_t                    c2_ctx;
  logic                        out_v_q;
  logic [31:0]                 o_local_q;
  logic [11:0]                 o_year_q;
  logic [3:0]                  o_month_q;
  logic [4:0]                  o_day_q, o_hour_q;
  logic [5:0]                  o_min_q, o_sec_q;
  logic [2:0]                  o_wd_q;
  logic                        o_dst_q;
  logic signed [10:0]          o_off_q;

  assign adv         = !out_v_q || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      auto_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_OFFSET: base_q <= signed'(cfg_wdata_i[10:0]);
        REG_AUTO_DST:    auto_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0; s1_v_q <= 1'b0; s2_v_q <= 1'b0;
      d1_v_q <= 1'b0; d2_v_q <= 1'b0; d3_v_q <= 1'b0; d4_v_q <= 1'b0; d5_v_q <= 1'b0;
      l1_v_q <= 1'b0; l2_v_q <= 1'b0; l3_v_q <= 1'b0; l4_v_q <= 1'b0; l5_v_q <= 1'b0;
      l6_v_q <= 1'b0; out_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_ch.valid; s1_v_q <= s0_v_q; s2_v_q <= s1_v_q;
      d1_v_q <= c1_v; d2_v_q <= d1_v_q; d3_v_q <= d2_v_q; d4_v_q <= d3_v_q;
      d5_v_q <= d4_v_q;
      l1_v_q <= d5_v_q; l2_v_q <= l1_v_q; l3_v_q <= l2_v_q; l4_v_q <= l3_v_q;
      l5_v_q <= l4_v_q; l6_v_q <= l5_v_q;
      out_v_q <= c2_v;
    end
  end

  // UTC day split
  assign p_ud = 51'(s0_utc_q[31:7]) * 51'(M675);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_utc_q  <= in_ch.utc_seconds;
      s0_sync_q <= in_ch.clock_synced;
      s0_base_q <= base_q;
      s0_auto_q <= auto_q;
      s1_ud_q   <= p_ud[50:35];
      s1_utc_q  <= s0_utc_q;
      s1_sync_q <= s0_sync_q;
      s1_base_q <= s0_base_q;
      s1_auto_q <= s0_auto_q;
      s2_q.utc      <= s1_utc_q;
      s2_q.ud       <= s1_ud_q;
      s2_q.usecs    <= 17'(33'(s1_utc_q) - 33'(s1_ud_q) * 33'd86400);
      s2_q.sync     <= s1_sync_q;
      s2_q.base     <= s1_base_q;
      s2_q.auto_dst <= s1_auto_q;
    end
  end

  edst_civil #(.SbW($bits(utc_ctx_t))) u_civil_utc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_v_q),
    .days_i  (s2_q.ud),
    .sb_i    (s2_q),
    .valid_o (c1_v),
    .year_o  (c1_year),
    .month_o (c1_month),
    .day_o   (c1_day),
    .sb_o    (c1_sb)
  );
  assign c1_ctx = c1_sb;

  // Day number of March 1 of the UTC year (only 2100 skips a leap day here)
  assign d_mar1 = 17'd59 + 17'(8'(c1_year - 12'd1970)) * 17'd365 + 17'(c1_year[11:2])
                  - 17'd492 - 17'(c1_year >= 12'd2100);

  assign p_wm = 34'(d1_m_q + 17'd4) * 34'(M7);
  assign p_wo = 34'(d1_o_q + 17'd4) * 34'(M7);
  assign wdm  = 3'((d2_m_q + 17'd4) - 17'(d2_qm_q) * 17'd7);
  assign wdo  = 3'((d2_o_q + 17'd4) - 17'(d2_qo_q) * 17'd7);

  assign aft_start = (17'(d3_q.ud) > d3_m_q) ||
                     ((17'(d3_q.ud) == d3_m_q) && (d3_q.usecs >= 17'd3600));
  assign bef_end   = (17'(d3_q.ud) < d3_o_q) ||
                     ((17'(d3_q.ud) == d3_o_q) && (d3_q.usecs < 17'd3600));
  assign dst_d     = d3_q.sync && d3_q.auto_dst && aft_start && bef_end;
  assign off_d     = $signed({d3_q.base[10], d3_q.base}) + (dst_d ? 12'sd60 : 12'sd0);
  assign off_sec   = $signed({{6{d4_off_q[11]}}, d4_off_q}) * 18'sd60;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q      <= c1_ctx;
      d1_m_q    <= d_mar1 + 17'd30;
      d1_o_q    <= d_mar1 + 17'd244;
      d2_q      <= d1_q;
      d2_m_q    <= d1_m_q;
      d2_o_q    <= d1_o_q;
      d2_qm_q   <= p_wm[31:19];
      d2_qo_q   <= p_wo[31:19];
      d3_q      <= d2_q;
      d3_m_q    <= d2_m_q - 17'(wdm);
      d3_o_q    <= d2_o_q - 17'(wdo);
      d4_off_q  <= off_d;
      d4_dst_q  <= dst_d;
      d4_sync_q <= d3_q.sync;
      d4_utc_q  <= d3_q.utc;
      d5_q.local_sec <= d4_utc_q + {{14{off_sec[17]}}, off_sec};
      d5_q.off       <= d4_off_q[10:0];
      d5_q.dst       <= d4_dst_q;
      d5_q.sync      <= d4_sync_q;
    end
  end

  // Local day split and time of day
  assign p_ld = 51'(d5_q.local_sec[31:7]) * 51'(M675);
  assign p_hr = 35'(l2_secs_q) * 35'(M3600);
  assign p_wd = 34'(17'(l2_ld_q) + 17'd4) * 34'(M7);
  assign p_mn = 25'(l4_rem_q) * 25'(M60);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1_q      <= d5_q;
      l1_ld_q   <= p_ld[50:35];
      l2_q      <= l1_q;
      l2_ld_q   <= l1_ld_q;
      l2_secs_q <= 17'(33'(l1_q.local_sec) - 33'(l1_ld_q) * 33'd86400);
      l3_q      <= l2_q;
      l3_ld_q   <= l2_ld_q;
      l3_secs_q <= l2_secs_q;
      l3_hour_q <= p_hr[33:29];
      l3_wq_q   <= p_wd[31:19];
      l4_q      <= l3_q;
      l4_ld_q   <= l3_ld_q;
      l4_hour_q <= l3_hour_q;
      l4_rem_q  <= 12'(l3_secs_q - 17'(l3_hour_q) * 17'd3600);
      l4_wd_q   <= 3'((17'(l3_ld_q) + 17'd4) - 17'(l3_wq_q) * 17'd7);
      l5_q      <= l4_q;
      l5_ld_q   <= l4_ld_q;
      l5_hour_q <= l4_hour_q;
      l5_rem_q  <= l4_rem_q;
      l5_wd_q   <= l4_wd_q;
      l5_min_q  <= p_mn[23:18];
      l6_ld_q     <= l5_ld_q;
      l6_q.ctx    <= l5_q;
      l6_q.hour   <= l5_hour_q;
      l6_q.minute <= l5_min_q;
      l6_q.second <= 6'(l5_rem_q - 12'(l5_min_q) * 12'd60);
      l6_q.wday   <= l5_wd_q;
    end
  end

  edst_civil #(.SbW($bits(hms_ctx_t))) u_civil_loc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (l6_v_q),
    .days_i  (l6_ld_q),
    .sb_i    (l6_q),
    .valid_o (c2_v),
    .year_o  (c2_year),
    .month_o (c2_month),
    .day_o   (c2_day),
    .sb_o    (c2_sb)
  );
  assign c2_ctx = c2_sb;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_off_q <= c2_ctx.ctx.off;
      if (c2_ctx.ctx.sync) begin
        o_local_q <= c2_ctx.ctx.local_sec;
        o_year_q  <= c2_year;
        o_month_q <= c2_month;
        o_day_q   <= c2_day;
        o_hour_q  <= c2_ctx.hour;
        o_min_q   <= c2_ctx.minute;
        o_sec_q   <= c2_ctx.second;
        o_wd_q    <= c2_ctx.wday;
        o_dst_q   <= c2_ctx.ctx.dst;
      end else begin
        o_local_q <= '0;
        o_year_q  <= '0;
        o_month_q <= '0;
        o_day_q   <= '0;
        o_hour_q  <= '0;
        o_min_q   <= '0;
        o_sec_q   <= '0;
        o_wd_q    <= '0;
        o_dst_q   <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_v_q;
  assign out_ch.local_seconds  = o_local_q;
  assign out_ch.local_year     = o_year_q;
  assign out_ch.local_month    = o_month_q;
  assign out_ch.local_day      = o_day_q;
  assign out_ch.local_hour     = o_hour_q;
  assign out_ch.local_minute   = o_min_q;
  assign out_ch.local_second   = o_sec_q;
  assign out_ch.week_day       = o_wd_q;
  assign out_ch.summer_time    = o_dst_q;
  assign out_ch.offset_minutes = o_off_q;

`ifndef SYNTH
  a_dst_months: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && o_dst_q |-> (o_month_q >= 4'd3) && (o_month_q <= 4'd10))
    else $error("summer time flagged outside March to October");

  a_date_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (o_month_q != 4'd0) |-> (o_day_q != 5'd0) && (o_year_q >= 12'd1970))
    else $error("partial date on a synced result");

  a_unsynced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (o_month_q == 4'd0) |-> !o_dst_q && (o_local_q == 32'd0) &&
    (o_year_q == 12'd0))
    else $error("unsynced result carries nonzero fields");

  a_utc_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c1_v |-> (c1_month >= 4'd1) && (c1_month <= 4'd12) && (c1_day != 5'd0))
    else $error("UTC calendar stage gave an invalid date");
`endif

endmodule
